// ----- rtl/cadt_pkg.sv -----
// Package for the CIDR allow/deny table: command codes, the request token
// that travels along the cell chain, and the prefix mask helper.
// No dependencies; used by cadt_cell, cidr_allow_deny_table and the testbench.
package cadt_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned HbW    = 6;
  localparam int unsigned FlagW  = 2;
  localparam logic [HbW-1:0] HbMax = 6'd32;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Request token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             active;  // a request occupies this stage
    logic             claim;   // insert second pass: take the lowest free slot
    logic [1:0]       cmd;
    logic [AddrW-1:0] addr;    // address as given, used by lookup
    logic [AddrW-1:0] base;    // address with host bits cleared
    logic [HbW-1:0]   hb;      // host-bit count, limited to 32
    logic [FlagW-1:0] flags;
    logic             allow;   // lookup hit an allow entry so far
    logic             deny;    // lookup hit a deny entry so far
    logic             found;   // insert matched an existing entry
    logic             done;    // insert claim pass took a slot
  } tok_t;

  // Network mask for a host-bit count; a count of 32 or more gives zero.
  function automatic logic [AddrW-1:0] net_mask(input logic [HbW-1:0] hb);
    net_mask = {AddrW{1'b1}} << hb;
  endfunction

endpackage

// ----- rtl/cadt_cell.sv -----
// One slot of the CIDR allow/deny table plus the chain register that passes
// the request token on to the next slot.
// Depends on cadt_pkg.
module cadt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cadt_pkg::tok_t tok_i,
  output cadt_pkg::tok_t tok_o
);
  import cadt_pkg::*;

  logic             valid_q, valid_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [HbW-1:0]   hb_q, hb_d;
  logic [FlagW-1:0] flags_q, flags_d;
  tok_t             tok_q, tok_d;
  logic             hit;
  logic             lk_hit;

  // Exact entry match for insert and delete, prefix match for lookup.
  assign hit    = valid_q && (base_q == tok_i.base) && (hb_q == tok_i.hb);
  assign lk_hit = valid_q && ((tok_i.addr & net_mask(hb_q)) == base_q);

  // Apply the passing request to this slot and update the token.
  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    base_d  = base_q;
    hb_d    = hb_q;
    flags_d = flags_q;
    if (tok_i.active) begin
      case (tok_i.cmd)
        CMD_INSERT: begin
          if (tok_i.claim) begin
            if (!valid_q && !tok_i.done) begin
              valid_d    = 1'b1;
              base_d     = tok_i.base;
              hb_d       = tok_i.hb;
              flags_d    = tok_i.flags;
              tok_d.done = 1'b1;
            end
          end else if (hit) begin
            flags_d     = flags_q | tok_i.flags;
            tok_d.found = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (hit) begin
            flags_d = flags_q & ~tok_i.flags;
            if (flags_d == '0) begin
              valid_d = 1'b0;
            end
          end
        end
        CMD_LOOKUP: begin
          if (lk_hit) begin
            tok_d.allow = tok_i.allow | flags_q[0];
            tok_d.deny  = tok_i.deny | flags_q[1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state: slot valid and the chain token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Payload: slot contents.
  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    hb_q    <= hb_d;
    flags_q <= flags_d;
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/cidr_allow_deny_table.sv -----
// CIDR allow/deny table built as a chain of TABLE_ENTRIES slot cells.
// An accepted request is loaded into the injection register and walks the cell chain
// one cell a cycle; an insert that matches no entry walks it a second time to claim a
// free slot. The result then passes a pending register and the output register.
// One request at a time: the next is taken once the result enters the output register.
// Reset clears all slot valid bits at once; slot contents are not cleared.
module cidr_allow_deny_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  input  logic [cadt_pkg::AddrW-1:0] addr_i,
  input  logic [cadt_pkg::HbW-1:0]   host_bits_i,
  input  logic [cadt_pkg::FlagW-1:0] list_flags_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   in_allow_o,
  output logic                   in_deny_o,
  output logic                   status_o
);
  import cadt_pkg::*;

  tok_t           chain [TABLE_ENTRIES+1];
  tok_t           inj_q, inj_d;
  tok_t           tok_last;
  logic [HbW-1:0] hb_n;
  logic           accept;
  logic           reinj;
  logic           finish;
  logic           out_load;
  logic           busy_q, busy_d;
  logic           pend_valid_q, pend_valid_d;
  logic           pend_allow_q, pend_deny_q, pend_status_q;
  logic           out_valid_q, out_valid_d;
  logic           out_allow_q, out_deny_q, out_status_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;
  assign hb_n       = (host_bits_i > HbMax) ? HbMax : host_bits_i;

  // The cell chain: the injection register feeds the first cell.
  assign chain[0] = inj_q;
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cadt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end
  assign tok_last = chain[TABLE_ENTRIES];

  // An insert that found no matching entry walks the chain again to claim a slot.
  assign reinj  = tok_last.active && (tok_last.cmd == CMD_INSERT) &&
                  !tok_last.claim && !tok_last.found;
  assign finish = tok_last.active && !reinj;

  // Build the token for a new request or for the claim pass.
  always_comb begin
    inj_d        = tok_last;
    inj_d.active = 1'b0;
    if (accept) begin
      inj_d.active = 1'b1;
      inj_d.claim  = 1'b0;
      inj_d.cmd    = cmd_i;
      inj_d.addr   = addr_i;
      inj_d.base   = addr_i & net_mask(hb_n);
      inj_d.hb     = hb_n;
      inj_d.flags  = list_flags_i;
      inj_d.allow  = 1'b0;
      inj_d.deny   = 1'b0;
      inj_d.found  = 1'b0;
      inj_d.done   = 1'b0;
    end else if (reinj) begin
      inj_d.active = 1'b1;
      inj_d.claim  = 1'b1;
    end
  end

  // Result staging: a pending register, then the output register.
  assign out_load = pend_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (finish) begin
      pend_valid_d = 1'b1;
    end else if (out_load) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (out_load) begin
      busy_d = 1'b0;
    end
  end

  // Control registers and the injection token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q        <= '0;
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      inj_q        <= inj_d;
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      pend_allow_q  <= tok_last.allow;
      pend_deny_q   <= tok_last.deny;
      pend_status_q <= tok_last.claim && !tok_last.done;
    end
    if (out_load) begin
      out_allow_q  <= pend_allow_q;
      out_deny_q   <= pend_deny_q;
      out_status_q <= pend_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_allow_o  = out_allow_q;
  assign in_deny_o   = out_deny_q;
  assign status_o    = out_status_q;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for cidr_allow_deny_table: drives insert, delete, lookup and
// command 3 requests, predicts every result with its own table model and compares them
// in order. Depends on cadt_pkg and the cidr_allow_deny_table RTL.
`timescale 1ns / 1ps

module tb;
  import cadt_pkg::*;

  localparam int unsigned TABLE_SLOTS = 64;
  // Command 3 has no name in the package; the table must ignore it.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // The worst request makes two passes over the cell chain, then goes through the result staging.
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 72;

  // Table predictor and the queue of verdicts it still expects from the block.
  class cidr_scoreboard;
    typedef struct packed {
      logic allow;
      logic deny;
      logic status;
    } verdict_t;

    logic        slot_used   [TABLE_SLOTS];
    logic [31:0] slot_prefix [TABLE_SLOTS];
    logic [5:0]  slot_hb     [TABLE_SLOTS];
    logic [1:0]  slot_lists  [TABLE_SLOTS];
    verdict_t    pending_verdicts [$];
    int          errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    // Bits that survive in a prefix with the given host-bit count.
    static function logic [31:0] keep_mask(logic [5:0] hb);
      return (hb >= 6'd32) ? 32'h0 : (32'hFFFF_FFFF << hb);
    endfunction

    // Apply one accepted request to the table and queue the verdict it produces.
    function void note_request(logic [1:0] cmd, logic [31:0] addr, logic [5:0] hb_in,
                               logic [1:0] lists);
      verdict_t    v;
      logic [5:0]  hb;
      logic [31:0] base;
      int          hit;
      int          free_idx;
      v = '0;
      hb = (hb_in > 6'd32) ? 6'd32 : hb_in;
      base = addr & keep_mask(hb);
      hit = -1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (hit < 0 && slot_used[i] && slot_prefix[i] == base && slot_hb[i] == hb) hit = i;
      end
      case (cmd)
        CMD_INSERT: begin
          if (hit >= 0) begin
            slot_lists[hit] = slot_lists[hit] | lists;
          end else begin
            free_idx = -1;
            for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
              if (!slot_used[i]) free_idx = i;
            end
            if (free_idx >= 0) begin
              slot_used[free_idx]   = 1'b1;
              slot_prefix[free_idx] = base;
              slot_hb[free_idx]     = hb;
              slot_lists[free_idx]  = lists;
            end else begin
              v.status = 1'b1;
            end
          end
        end
        CMD_DELETE: begin
          if (hit >= 0) begin
            slot_lists[hit] = slot_lists[hit] & ~lists;
            if (slot_lists[hit] == 2'b00) slot_used[hit] = 1'b0;
          end
        end
        CMD_LOOKUP: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i] && (addr & keep_mask(slot_hb[i])) == slot_prefix[i]) begin
              v.allow = v.allow | slot_lists[i][0];
              v.deny  = v.deny  | slot_lists[i][1];
            end
          end
        end
        default: ;
      endcase
      pending_verdicts.push_back(v);
    endfunction

    // Compare one result from the block with the oldest expected verdict.
    function void check_result(logic allow, logic deny, logic status);
      verdict_t exp_v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result allow %0b deny %0b status %0b",
                 $time, allow, deny, status);
        errors++;
        return;
      end
      exp_v = pending_verdicts.pop_front();
      if (allow !== exp_v.allow) begin
        $display("%0t: in_allow expected %0b, got %0b", $time, exp_v.allow, allow);
        errors++;
      end
      if (deny !== exp_v.deny) begin
        $display("%0t: in_deny expected %0b, got %0b", $time, exp_v.deny, deny);
        errors++;
      end
      if (status !== exp_v.status) begin
        $display("%0t: status expected %0b, got %0b", $time, exp_v.status, status);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i        = CMD_LOOKUP;
  logic [31:0] addr_i       = 32'h0;
  logic [5:0]  host_bits_i  = 6'd0;
  logic [1:0]  list_flags_i = 2'b00;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        in_allow_o;
  logic        in_deny_o;
  logic        status_o;

  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int rx_hold_cycles = 0;

  // Recently used prefixes, so that random requests hit existing entries.
  logic [31:0] prefix_addr [$];
  logic [5:0]  prefix_hb   [$];

  cidr_scoreboard sb = new();

  cidr_allow_deny_table #(
    .TABLE_ENTRIES(TABLE_SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .addr_i       (addr_i),
    .host_bits_i  (host_bits_i),
    .list_flags_i (list_flags_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .in_allow_o   (in_allow_o),
    .in_deny_o    (in_deny_o),
    .status_o     (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run in case the block hangs.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: check accepted results, stall at random, or hold off for a long stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(in_allow_o, in_deny_o, status_o);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one request, with an optional random gap first, and wait until it is taken.
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] addr,
                              input logic [5:0] hb, input logic [1:0] lists);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    addr_i       <= addr;
    host_bits_i  <= hb;
    list_flags_i <= lists;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, addr, hb, lists);
  endtask

  // Stop offering requests until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // A fresh prefix: random, in a shared region, nested in a known one, or 32+ host bits.
  task automatic make_prefix(output logic [31:0] a, output logic [5:0] hb);
    int r;
    int j;
    r = $urandom_range(99);
    a = $urandom;
    if (r < 4) begin
      hb = 6'($urandom_range(63, 32));
    end else if (r < 20 && prefix_addr.size() > 0) begin
      j = $urandom_range(prefix_addr.size() - 1);
      hb = (prefix_hb[j] > 6'd32) ? 6'd32 : prefix_hb[j];
      hb = 6'($urandom_range(hb));
      a = prefix_addr[j] ^ (a & ~sb.keep_mask(prefix_hb[j]));
    end else begin
      hb = 6'($urandom_range(31));
      if (r < 50) a[31:24] = 8'h0A;
    end
  endtask

  // One random request; the weights pick insert, delete and lookup, the rest is command 3.
  task automatic random_request(input int ins_w, input int del_w, input int look_w);
    logic [31:0] a;
    logic [5:0]  hb;
    int          r;
    int          j;
    r = $urandom_range(99);
    j = (prefix_addr.size() > 0) ? $urandom_range(prefix_addr.size() - 1) : 0;
    if (r < ins_w) begin
      if (prefix_addr.size() > 0 && $urandom_range(99) < 35) begin
        a = prefix_addr[j] ^ ($urandom & ~sb.keep_mask(prefix_hb[j]));
        send_request(CMD_INSERT, a, prefix_hb[j], 2'($urandom_range(3)));
      end else begin
        make_prefix(a, hb);
        prefix_addr.push_back(a);
        prefix_hb.push_back(hb);
        if (prefix_addr.size() > 48) begin
          void'(prefix_addr.pop_front());
          void'(prefix_hb.pop_front());
        end
        send_request(CMD_INSERT, a, hb, 2'($urandom_range(3)));
      end
    end else if (r < ins_w + del_w) begin
      if (prefix_addr.size() > 0 && $urandom_range(99) < 80) begin
        a = prefix_addr[j] ^ ($urandom & ~sb.keep_mask(prefix_hb[j]));
        send_request(CMD_DELETE, a, prefix_hb[j], 2'($urandom_range(3)));
      end else begin
        send_request(CMD_DELETE, $urandom, 6'($urandom_range(63)), 2'($urandom_range(3)));
      end
    end else if (r < ins_w + del_w + look_w) begin
      if (prefix_addr.size() > 0 && $urandom_range(99) < 75) begin
        a = prefix_addr[j] ^ ($urandom & ~sb.keep_mask(prefix_hb[j]));
      end else begin
        a = $urandom;
      end
      send_request(CMD_LOOKUP, a, 6'($urandom_range(63)), 2'($urandom_range(3)));
    end else begin
      send_request(CMD_SPARE, $urandom, 6'($urandom_range(63)), 2'($urandom_range(3)));
    end
  endtask

  task automatic run_phase(input int count, input int tx_pct, input int rx_pct,
                           input int ins_w, input int del_w, input int look_w);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) random_request(ins_w, del_w, look_w);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, flag merging, delete, host bits at and above 32,
    // zero flags, missing entries and the unused command.
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 2'b00);
    send_request(CMD_INSERT, 32'hC0A8_0100, 6'd8, 2'b01);
    send_request(CMD_INSERT, 32'hC0A8_01FF, 6'd8, 2'b10);
    send_request(CMD_LOOKUP, 32'hC0A8_0123, 6'd0, 2'b00);
    send_request(CMD_DELETE, 32'hC0A8_0177, 6'd8, 2'b01);
    send_request(CMD_LOOKUP, 32'hC0A8_0123, 6'd63, 2'b11);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 6'd63, 2'b01);
    send_request(CMD_LOOKUP, 32'h1234_5678, 6'd0, 2'b00);
    send_request(CMD_INSERT, 32'hDEAD_BEEF, 6'd0, 2'b10);
    send_request(CMD_LOOKUP, 32'hDEAD_BEEF, 6'd0, 2'b00);
    send_request(CMD_LOOKUP, 32'hDEAD_BEEE, 6'd0, 2'b00);
    send_request(CMD_INSERT, 32'h5555_5555, 6'd5, 2'b00);
    send_request(CMD_LOOKUP, 32'h5555_5540, 6'd0, 2'b00);
    send_request(CMD_DELETE, 32'h0000_0000, 6'd0, 2'b11);
    send_request(CMD_SPARE, 32'hFFFF_FFFF, 6'd63, 2'b11);
    send_request(CMD_DELETE, 32'hAAAA_AAAA, 6'd32, 2'b11);
    send_request(CMD_DELETE, 32'hDEAD_BEEF, 6'd0, 2'b10);
    send_request(CMD_DELETE, 32'hAAAA_AAAA, 6'd40, 2'b11);
    send_request(CMD_INSERT, 32'h0000_0000, 6'd32, 2'b11);
    send_request(CMD_LOOKUP, 32'h0000_0000, 6'd0, 2'b00);
    send_request(CMD_DELETE, 32'h8000_0001, 6'd33, 2'b11);
    send_request(CMD_LOOKUP, 32'hC0A8_01FE, 6'd32, 2'b11);

    // Random part, phases with varied idling; the fill phases overflow the table.
    run_phase(200, 0, 0, 45, 15, 38);
    run_phase(200, 51, 0, 80, 3, 15);

    // Long receiver hold-off with the sender still offering requests.
    wait_drained();
    rx_hold_cycles = 400;
    run_phase(20, 0, 0, 45, 15, 38);

    run_phase(200, 0, 51, 25, 45, 28);
    run_phase(200, 20, 20, 45, 15, 38);
    wait_drained();
    run_phase(200, 0, 0, 75, 5, 18);
    run_phase(180, 51, 51, 45, 15, 38);

    // Wrap up once every result is back and the block has had time to go quiet.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
